FILE: sv/gf125_pkg.sv
// ----------------------------------------------------------------------------
// gf125_pkg
// Shared types, mode codes and mod-5 helpers for the GF(5^3) arithmetic unit.
// ----------------------------------------------------------------------------
package gf125_pkg;

    localparam int unsigned COEF_W   = 3;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned SCALAR_W = 8;
    localparam int unsigned SUM_W    = 8;

    localparam logic [SUM_W-1:0] GF_P = 8'd5;

    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SMUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AUTO1 = 3'd4;
    localparam logic [MODE_W-1:0] MODE_AUTO2 = 3'd5;

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        coef_t                      a_c0;
        coef_t                      a_c1;
        coef_t                      a_c2;
        coef_t                      b_c0;
        coef_t                      b_c1;
        coef_t                      b_c2;
        logic signed [SCALAR_W-1:0] scalar;
    } operand_t;

    typedef struct packed {
        coef_t r_c0;
        coef_t r_c1;
        coef_t r_c2;
        logic  a_is_zero;
        logic  a_equals_b;
    } result_t;

    // reduce an 8-bit value mod 5, using 16 = 1 (mod 5) to fold nibbles
    function automatic coef_t mod5(input sum_t v);
        logic [4:0] f1;
        logic [4:0] f2;
        coef_t      r;
        f1 = 5'(v[7:4]) + 5'(v[3:0]);
        f2 = 5'(f1[4]) + 5'(f1[3:0]);
        priority if (f2 >= 5'd15)
            r = 3'(f2 - 5'd15);
        else if (f2 >= 5'd10)
            r = 3'(f2 - 5'd10);
        else if (f2 >= 5'd5)
            r = 3'(f2 - 5'd5);
        else
            r = 3'(f2);
        return r;
    endfunction

    // coefficient fields may hold 5..7
    function automatic coef_t red_coef(input coef_t c);
        coef_t r;
        r = (c >= 3'd5) ? 3'(c - 3'd5) : c;
        return r;
    endfunction

    // signed scalar into 0..4; 256 = 1 (mod 5), so negative values lose one
    function automatic coef_t scalar_mod5(input logic signed [SCALAR_W-1:0] s);
        coef_t u;
        coef_t r;
        u = mod5(sum_t'(s));
        if (s[SCALAR_W-1])
            r = (u == 3'd0) ? 3'd4 : 3'(u - 3'd1);
        else
            r = u;
        return r;
    endfunction

endpackage

FILE: sv/gf125_in_if.sv
// ----------------------------------------------------------------------------
// gf125_in_if
// Operand channel: valid/ready handshake carrying mode, operands and scalar.
// ----------------------------------------------------------------------------
interface gf125_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [2:0]        a_c0;
    logic [2:0]        a_c1;
    logic [2:0]        a_c2;
    logic [2:0]        b_c0;
    logic [2:0]        b_c1;
    logic [2:0]        b_c2;
    logic signed [7:0] scalar;

    modport source (
        output valid, mode, a_c0, a_c1, a_c2, b_c0, b_c1, b_c2, scalar,
        input  ready
    );

    modport sink (
        input  valid, mode, a_c0, a_c1, a_c2, b_c0, b_c1, b_c2, scalar,
        output ready
    );
endinterface

FILE: sv/gf125_out_if.sv
// ----------------------------------------------------------------------------
// gf125_out_if
// Result channel: valid/ready handshake carrying the result element and flags.
// ----------------------------------------------------------------------------
interface gf125_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] r_c0;
    logic [2:0] r_c1;
    logic [2:0] r_c2;
    logic       a_is_zero;
    logic       a_equals_b;

    modport source (
        output valid, r_c0, r_c1, r_c2, a_is_zero, a_equals_b,
        input  ready
    );

    modport sink (
        input  valid, r_c0, r_c1, r_c2, a_is_zero, a_equals_b,
        output ready
    );
endinterface

FILE: sv/gf125_datapath.sv
// ----------------------------------------------------------------------------
// gf125_datapath
// Field operations on one registered operand set; alpha^3 = 2*alpha + 2.
// ----------------------------------------------------------------------------
module gf125_datapath (
    input  gf125_pkg::operand_t op,
    output gf125_pkg::result_t  res
);

    gf125_pkg::coef_t a0, a1, a2, b0, b1, b2, k;
    gf125_pkg::sum_t  s0, s1, s2;

    always_comb
    begin
        a0 = gf125_pkg::red_coef(op.a_c0);
        a1 = gf125_pkg::red_coef(op.a_c1);
        a2 = gf125_pkg::red_coef(op.a_c2);
        b0 = gf125_pkg::red_coef(op.b_c0);
        b1 = gf125_pkg::red_coef(op.b_c1);
        b2 = gf125_pkg::red_coef(op.b_c2);
        k  = gf125_pkg::scalar_mod5(op.scalar);
    end

    always_comb
    begin
        s0 = '0;
        s1 = '0;
        s2 = '0;
        unique case (op.mode)
            gf125_pkg::MODE_ADD:
            begin
                s0 = 8'(a0) + 8'(b0);
                s1 = 8'(a1) + 8'(b1);
                s2 = 8'(a2) + 8'(b2);
            end
            gf125_pkg::MODE_SUB:
            begin
                s0 = 8'(a0) + gf125_pkg::GF_P - 8'(b0);
                s1 = 8'(a1) + gf125_pkg::GF_P - 8'(b1);
                s2 = 8'(a2) + gf125_pkg::GF_P - 8'(b2);
            end
            gf125_pkg::MODE_MUL:
            begin
                // alpha^4 = 2*alpha^2 + 2*alpha folds the high terms back
                s0 = 8'(a0) * 8'(b0) + 8'd2 * 8'(a2) * 8'(b1) + 8'd2 * 8'(a1) * 8'(b2);
                s1 = 8'(a1) * 8'(b0) + 8'(a0) * 8'(b1) + 8'd2 * 8'(a2) * 8'(b1)
                   + 8'd2 * 8'(a1) * 8'(b2) + 8'd2 * 8'(a2) * 8'(b2);
                s2 = 8'(a2) * 8'(b0) + 8'(a1) * 8'(b1) + 8'(a0) * 8'(b2)
                   + 8'd2 * 8'(a2) * 8'(b2);
            end
            gf125_pkg::MODE_SMUL:
            begin
                s0 = 8'(k) * 8'(a0);
                s1 = 8'(k) * 8'(a1);
                s2 = 8'(k) * 8'(a2);
            end
            gf125_pkg::MODE_AUTO1:
            begin
                s0 = 8'(a0) + 8'(a1) + 8'(a2);
                s1 = 8'd3 * 8'(a2);
                s2 = 8'd3 * 8'(a1) + 8'd4 * 8'(a2);
            end
            gf125_pkg::MODE_AUTO2:
            begin
                s0 = 8'(a0) + 8'd4 * 8'(a1) + 8'd3 * 8'(a2);
                s1 = 8'd4 * 8'(a1) + 8'd2 * 8'(a2);
                s2 = 8'd2 * 8'(a1);
            end
            default:
            begin
                // unused modes give the zero element
                s0 = '0;
                s1 = '0;
                s2 = '0;
            end
        endcase
    end

    always_comb
    begin
        res.r_c0       = gf125_pkg::mod5(s0);
        res.r_c1       = gf125_pkg::mod5(s1);
        res.r_c2       = gf125_pkg::mod5(s2);
        res.a_is_zero  = (a0 == 3'd0) && (a1 == 3'd0) && (a2 == 3'd0);
        res.a_equals_b = (a0 == b0) && (a1 == b1) && (a2 == b2);
    end

endmodule

FILE: sv/gf125_arithmetic_unit.sv
// path: an accepted operand goes to the input reg, then to the result reg (result valid)
// throughput: one item per cycle; both stages advance together when not stalled
// a stalled result blocks the result reg; the input reg still fills behind it while empty
// reset: rst_n async active low clears both stage valids, no item in flight
// ----------------------------------------------------------------------------
// gf125_arithmetic_unit
// GF(5^3) add, subtract, multiply, scalar multiply and two automorphisms.
// ----------------------------------------------------------------------------
module gf125_arithmetic_unit (
    input  logic         clk,
    input  logic         rst_n,
    gf125_in_if.sink     operand,
    gf125_out_if.source  result
);

    gf125_pkg::operand_t op_reg;
    logic                op_valid_reg;
    gf125_pkg::result_t  res_reg;
    logic                res_valid_reg;
    gf125_pkg::result_t  res_next;
    logic                res_adv;
    logic                op_adv;

    assign res_adv       = !res_valid_reg || result.ready;
    assign op_adv        = !op_valid_reg || res_adv;
    assign operand.ready = op_adv;

    gf125_datapath u_datapath (
        .op  (op_reg),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_adv)
                op_valid_reg <= operand.valid;
            if (res_adv)
                res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_adv && operand.valid)
        begin
            op_reg.mode   <= operand.mode;
            op_reg.a_c0   <= operand.a_c0;
            op_reg.a_c1   <= operand.a_c1;
            op_reg.a_c2   <= operand.a_c2;
            op_reg.b_c0   <= operand.b_c0;
            op_reg.b_c1   <= operand.b_c1;
            op_reg.b_c2   <= operand.b_c2;
            op_reg.scalar <= operand.scalar;
        end
        if (res_adv && op_valid_reg)
            res_reg <= res_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.r_c0       = res_reg.r_c0;
    assign result.r_c1       = res_reg.r_c1;
    assign result.r_c2       = res_reg.r_c2;
    assign result.a_is_zero  = res_reg.a_is_zero;
    assign result.a_equals_b = res_reg.a_equals_b;

`ifndef NO_ASSERTIONS
    // an item accepted at the input is held in the input stage next cycle
    a_op_capture: assert property (@(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready |=> op_valid_reg)
        else $error("accepted item not captured in input stage");

    // an item in the input stage moves to the result stage when it can
    a_res_advance: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && res_adv |=> result.valid)
        else $error("input stage item not moved to result stage");

    // result coefficients are always reduced
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.r_c0 <= 3'd4) && (result.r_c1 <= 3'd4)
                         && (result.r_c2 <= 3'd4))
        else $error("result coefficient out of range");

    // an item whose a is zero and equal to b keeps its zero flag in the result stage
    a_zero_eq: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && res_adv && res_next.a_is_zero && res_next.a_equals_b
        |=> result.a_is_zero)
        else $error("zero flag lost between stages");
`endif

endmodule
